FILE: sv/mau_pkg.sv
package mau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4,
    OP_NEG = 3'd5,
    OP_RED = 3'd6,
    OP_EQ  = 3'd7
  } op_t;

  localparam logic [2:0] MODULUS_ADDR = 3'd0;

endpackage

FILE: sv/modular_arithmetic_unit.sv
// Every transaction is reduced by the front part and then computed by the back part; add, sub,
// neg, reduce and eq need no more work, mul runs the multiplier, pow runs multiply rounds over the exponent bits.
// Div and negative pow add extended Euclid rounds; div adds one more multiply when the
// divisor is invertible.
// The front part can take a new transaction while the back part still works on the last one.
// Reset: synchronous active-low; modulus returns to 1000000007, both parts go idle.
module modular_arithmetic_unit #(
  parameter int MOD_BITS = 31,
  parameter int EXP_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_opcode,
  input  logic signed [63:0]  in_operand_a,
  input  logic signed [63:0]  in_operand_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MOD_BITS-1:0] out_result,
  output logic                out_not_invertible,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mau_pkg::*;

  logic [MOD_BITS-1:0] mod_r;
  logic [MOD_BITS-1:0] m_eff;
  logic                q_valid, q_stall;
  op_t                 q_op;
  logic [MOD_BITS-1:0] q_a, q_b;
  logic [63:0]         q_raw_b;

  always_ff @(posedge clk) begin
    if (!rst_n) mod_r <= MOD_BITS'(64'd1000000007);
    else if (psel && penable && pwrite && paddr == MODULUS_ADDR) mod_r <= MOD_BITS'(pwdata);
  end

  assign m_eff  = (mod_r < MOD_BITS'(2)) ? MOD_BITS'(1) : mod_r;
  assign pready = 1'b1;
  assign prdata = (paddr == MODULUS_ADDR) ? 32'(mod_r) : 32'd0;

  mau_front #(.MOD_BITS(MOD_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(op_t'(in_opcode)), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .m(m_eff), .q_valid(q_valid), .q_stall(q_stall),
    .q_op(q_op), .q_a(q_a), .q_b(q_b), .q_raw_b(q_raw_b)
  );

  mau_back #(.MOD_BITS(MOD_BITS), .EXP_BITS(EXP_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .m(m_eff), .q_valid(q_valid), .q_stall(q_stall),
    .q_op(q_op), .q_a(q_a), .q_b(q_b), .q_raw_b(q_raw_b), .out_valid(out_valid),
    .out_stall(out_stall), .out_result(out_result),
    .out_not_invertible(out_not_invertible)
  );
endmodule

FILE: sv/mau_divu.sv
module mau_divu #(
  parameter int NUM_BITS = 64,
  parameter int DEN_BITS = 62
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                busy,
  output logic                done,
  output logic [NUM_BITS-1:0] quot,
  output logic [DEN_BITS-1:0] rem
);
  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q_r;
  logic [DEN_BITS:0]   r_r;
  logic [DEN_BITS-1:0] d_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [DEN_BITS:0]   sh;
  logic [DEN_BITS:0]   df;

  assign sh = {r_r[DEN_BITS-1:0], q_r[NUM_BITS-1]};
  assign df = sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      r_r <= '0;
      d_r <= den;
    end else if (busy_r) begin
      if (!df[DEN_BITS]) begin
        r_r <= df;
        q_r <= {q_r[NUM_BITS-2:0], 1'b1};
      end else begin
        r_r <= sh;
        q_r <= {q_r[NUM_BITS-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r[DEN_BITS-1:0];
endmodule

FILE: sv/mau_front.sv
module mau_front #(
  parameter int MOD_BITS = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mau_pkg::op_t        in_opcode,
  input  logic [63:0]         in_operand_a,
  input  logic [63:0]         in_operand_b,
  input  logic [MOD_BITS-1:0] m,
  output logic                q_valid,
  input  logic                q_stall,
  output mau_pkg::op_t        q_op,
  output logic [MOD_BITS-1:0] q_a,
  output logic [MOD_BITS-1:0] q_b,
  output logic [63:0]         q_raw_b
);
  import mau_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_RA   = 4'b0010,
    F_RB   = 4'b0100,
    F_OUT  = 4'b1000
  } fst_t;

  fst_t          st_r;
  op_t           op_r;
  logic [63:0]   a_raw_r, b_raw_r;
  logic [MOD_BITS-1:0] a_r, b_r;
  logic          ds;
  logic [63:0]   dnum;
  logic          dbusy, ddone;
  logic [63:0]   dq;
  logic [MOD_BITS-1:0] drem;
  logic          cur_neg;
  logic [MOD_BITS-1:0] red;
  logic          kick_r;

  mau_divu #(.NUM_BITS(64), .DEN_BITS(MOD_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(ds), .num(dnum), .den(m),
    .busy(dbusy), .done(ddone), .quot(dq), .rem(drem)
  );

  assign cur_neg = (st_r == F_RA) ? a_raw_r[63] : b_raw_r[63];
  assign red = (cur_neg && drem != '0) ? m - drem : drem;

  always_comb begin
    ds   = kick_r;
    dnum = a_raw_r[63] ? (~a_raw_r + 64'd1) : a_raw_r;
    if (st_r == F_RA && ddone) begin
      ds   = 1'b1;
      dnum = b_raw_r[63] ? (~b_raw_r + 64'd1) : b_raw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      unique case (st_r)
        F_IDLE: if (in_valid) st_r <= F_RA;
        F_RA:   if (ddone) st_r <= F_RB;
        F_RB:   if (ddone) st_r <= F_OUT;
        F_OUT:  if (!q_stall) st_r <= F_IDLE;
        default: st_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) kick_r <= 1'b0;
    else kick_r <= (st_r == F_IDLE) && in_valid;
  end

  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_valid) begin
      op_r    <= in_opcode;
      a_raw_r <= in_operand_a;
      b_raw_r <= in_operand_b;
    end
    if (ddone && st_r == F_RA) a_r <= red;
    if (ddone && st_r == F_RB) b_r <= red;
  end

  logic unused;
  assign unused = dbusy ^ dq[0];

  assign in_stall = (st_r != F_IDLE);
  assign q_valid  = (st_r == F_OUT);
  assign q_op     = op_r;
  assign q_a      = a_r;
  assign q_b      = b_r;
  assign q_raw_b  = b_raw_r;
endmodule

FILE: sv/mau_back.sv
module mau_back #(
  parameter int MOD_BITS = 31,
  parameter int EXP_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [MOD_BITS-1:0] m,
  input  logic                q_valid,
  output logic                q_stall,
  input  mau_pkg::op_t        q_op,
  input  logic [MOD_BITS-1:0] q_a,
  input  logic [MOD_BITS-1:0] q_b,
  input  logic [63:0]         q_raw_b,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MOD_BITS-1:0] out_result,
  output logic                out_not_invertible
);
  import mau_pkg::*;
  localparam int MW = MOD_BITS;
  localparam int EC = $clog2(EXP_BITS + 1);
  localparam int MC = $clog2(MW + 1);

  typedef enum logic [9:0] {
    B_IDLE = 10'b0000000001,
    B_MUL  = 10'b0000000010,
    B_PSTP = 10'b0000000100,
    B_PSQ  = 10'b0000001000,
    B_EDIV = 10'b0000010000,
    B_EMUL = 10'b0000100000,
    B_EUPD = 10'b0001000000,
    B_FIN  = 10'b0010000000,
    B_DIVM = 10'b0100000000,
    B_OUT  = 10'b1000000000
  } bst_t;

  bst_t st_r, ret_r;
  op_t  op_r;
  logic [MW-1:0] a_r, res_r;
  logic          flag_r;
  logic [EXP_BITS-1:0] p_r;
  logic          neg_r;
  logic [EC-1:0] ecnt_r;
  logic [MW-1:0] x_r, acc_r;
  // shared shift-add multiplier
  logic [MW-1:0] ma_r, mb_r, mp_r;
  logic [MC-1:0] mcnt_r;
  logic          mp_r_valid_r;
  // extended Euclid
  logic [MW-1:0] r0_r, r1_r, s0_r, s1_r;
  logic [MW-1:0] one_m;
  logic [MW:0]   sadd, sa2;
  logic          ddone_seen_r;

  logic          dstart, dbusy, ddone;
  logic [MW-1:0] dq, drem;

  mau_divu #(.NUM_BITS(MW), .DEN_BITS(MW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(r0_r), .den(r1_r),
    .busy(dbusy), .done(ddone), .quot(dq), .rem(drem)
  );

  assign one_m = (m == MW'(1)) ? '0 : MW'(1);
  assign sadd = {1'b0, mp_r} + {1'b0, ma_r};
  assign sa2  = {1'b0, ma_r} + {1'b0, ma_r};

  function automatic logic [MW-1:0] addm(logic [MW:0] s, logic [MW-1:0] mm);
    logic [MW:0] d;
    d = s - {1'b0, mm};
    return d[MW] ? s[MW-1:0] : d[MW-1:0];
  endfunction

  function automatic logic [MW-1:0] subm(logic [MW-1:0] x, logic [MW-1:0] y,
                                         logic [MW-1:0] mm);
    logic [MW:0] t;
    t = (x >= y) ? {1'b0, x} - {1'b0, y} : {1'b0, x} + {1'b0, mm} - {1'b0, y};
    return t[MW-1:0];
  endfunction

  assign dstart = (st_r == B_EDIV) && (r1_r != '0) && !dbusy && !ddone && !ddone_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ddone_seen_r <= 1'b0;
      mp_r_valid_r <= 1'b0;
    end else begin
      unique case (st_r)
        B_IDLE: begin
          if (q_valid) begin
            op_r   <= q_op;
            a_r    <= q_a;
            flag_r <= 1'b0;
            neg_r  <= q_raw_b[63];
            p_r    <= EXP_BITS'(q_raw_b[63] ? ~q_raw_b + 64'd1 : q_raw_b);
            unique case (q_op)
              OP_ADD: begin res_r <= addm({1'b0, q_a} + {1'b0, q_b}, m); st_r <= B_OUT; end
              OP_SUB: begin res_r <= subm(q_a, q_b, m); st_r <= B_OUT; end
              OP_NEG: begin res_r <= (q_a == '0) ? '0 : m - q_a; st_r <= B_OUT; end
              OP_RED: begin res_r <= q_a; st_r <= B_OUT; end
              OP_EQ:  begin res_r <= (q_a == q_b) ? MW'(1) : '0; st_r <= B_OUT; end
              OP_MUL: begin
                ma_r <= q_a; mb_r <= q_b; mp_r <= '0; mcnt_r <= MC'(MW);
                ret_r <= B_FIN; st_r <= B_MUL;
              end
              OP_DIV: begin
                r0_r <= m; r1_r <= q_b; s0_r <= '0; s1_r <= one_m;
                ret_r <= B_DIVM; st_r <= B_EDIV;
              end
              default: begin
                x_r <= q_a; acc_r <= one_m; ecnt_r <= EC'(EXP_BITS);
                st_r <= B_PSTP;
              end
            endcase
          end
        end
        B_MUL: begin
          if (mcnt_r == '0) begin
            st_r <= ret_r;
          end else begin
            if (mb_r[0]) mp_r <= addm(sadd, m);
            ma_r   <= addm(sa2, m);
            mb_r   <= mb_r >> 1;
            mcnt_r <= mcnt_r - 1'b1;
          end
        end
        B_PSTP: begin
          if (ecnt_r == '0) begin
            if (neg_r) begin
              r0_r <= m; r1_r <= acc_r; s0_r <= '0; s1_r <= one_m;
              ret_r <= B_FIN; st_r <= B_EDIV;
            end else begin
              res_r <= acc_r; st_r <= B_OUT;
            end
          end else begin
            ma_r <= acc_r; mb_r <= p_r[0] ? x_r : '0; mp_r <= '0;
            mcnt_r <= MC'(MW); ret_r <= B_PSQ; st_r <= B_MUL;
          end
        end
        B_PSQ: begin
          if (mp_r_valid_r) begin
            x_r <= mp_r; p_r <= p_r >> 1; ecnt_r <= ecnt_r - 1'b1;
            mp_r_valid_r <= 1'b0; st_r <= B_PSTP;
          end else begin
            if (p_r[0]) acc_r <= mp_r;
            ma_r <= x_r; mb_r <= x_r; mp_r <= '0; mcnt_r <= MC'(MW);
            mp_r_valid_r <= 1'b1; ret_r <= B_PSQ; st_r <= B_MUL;
          end
        end
        B_EDIV: begin
          if (r1_r == '0) begin
            if (r0_r != MW'(1) && m != MW'(1)) begin
              flag_r <= 1'b1; res_r <= '0; st_r <= B_OUT;
            end else if (op_r == OP_DIV) begin
              ma_r <= a_r; mb_r <= s0_r; mp_r <= '0; mcnt_r <= MC'(MW);
              ret_r <= B_FIN; st_r <= B_MUL;
            end else begin
              res_r <= s0_r; st_r <= B_OUT;
            end
          end else if (ddone) begin
            ddone_seen_r <= 1'b1;
            ma_r <= (dq >= m) ? dq - m : dq; mb_r <= s1_r; mp_r <= '0;
            mcnt_r <= MC'(MW); ret_r <= B_EUPD; st_r <= B_MUL;
          end
        end
        B_EUPD: begin
          ddone_seen_r <= 1'b0;
          r0_r <= r1_r; r1_r <= drem;
          s0_r <= s1_r; s1_r <= subm(s0_r, mp_r, m);
          st_r <= B_EDIV;
        end
        B_FIN: begin
          res_r <= mp_r; st_r <= B_OUT;
        end
        B_OUT: if (!out_stall) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign q_stall            = (st_r != B_IDLE);
  assign out_valid          = (st_r == B_OUT);
  assign out_result         = res_r;
  assign out_not_invertible = flag_r;
endmodule

FILE: tb/modular_arithmetic_unit_checker.sv
module modular_arithmetic_unit_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [2:0]        in_opcode,
  input  logic [63:0]       in_operand_a,
  input  logic [63:0]       in_operand_b,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [30:0]       out_result,
  input  logic              out_not_invertible,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);
  import mau_pkg::*;

  typedef struct packed {
    logic [30:0] result;
    logic        not_invertible;
  } mod_result_t;

  mod_result_t       expected_q[$];
  logic [30:0]       modulus_reg;

  function automatic logic [63:0] eff_modulus(logic [30:0] m);
    return (m < 2) ? 64'd1 : {33'd0, m};
  endfunction

  function automatic logic [63:0] reduce_in(logic [63:0] raw, logic [63:0] m);
    logic [63:0] mag, r;
    if (raw[63]) begin
      mag = ~raw + 64'd1;
      r = mag % m;
      return (r != 0) ? m - r : 64'd0;
    end
    return raw % m;
  endfunction

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    return ((a % m) * (b % m)) % m;
  endfunction

  function automatic logic invert(logic [63:0] b, logic [63:0] m, output logic [63:0] inv);
    logic [63:0] r0, r1, r2, s0, s1, s2, q, t;
    r0 = m; r1 = b; s0 = 0; s1 = 64'd1 % m;
    while (r1 != 0) begin
      q = r0 / r1;
      r2 = r0 - q * r1;
      t = mulmod(q, s1, m);
      s2 = (s0 >= t) ? s0 - t : s0 + m - t;
      r0 = r1; r1 = r2;
      s0 = s1; s1 = s2;
    end
    inv = (r0 == 1) ? s0 : 64'd0;
    return r0 == 1;
  endfunction

  function automatic mod_result_t compute_mod_op(op_t op, logic [63:0] raw_a,
                                                  logic [63:0] raw_b, logic [30:0] mreg);
    logic [63:0] m, a, b, res, inv, p, x, acc, s;
    logic        flag;
    mod_result_t r;
    m = eff_modulus(mreg);
    a = reduce_in(raw_a, m);
    b = reduce_in(raw_b, m);
    res = 0;
    flag = 0;
    case (op)
      OP_ADD: begin
        s = a + b;
        res = (s >= m) ? s - m : s;
      end
      OP_SUB: res = (a >= b) ? a - b : a + m - b;
      OP_MUL: res = mulmod(a, b, m);
      OP_DIV: begin
        if (invert(b, m, inv)) res = mulmod(a, inv, m);
        else flag = 1;
      end
      OP_POW: begin
        p = raw_b[63] ? ~raw_b + 64'd1 : raw_b;
        x = a;
        acc = 64'd1 % m;
        for (int i = 0; i < 64; i++) begin
          if (p[i]) acc = mulmod(acc, x, m);
          x = mulmod(x, x, m);
        end
        if (raw_b[63]) begin
          if (invert(acc, m, inv)) res = inv;
          else flag = 1;
        end else begin
          res = acc;
        end
      end
      OP_NEG: res = (a == 0) ? 64'd0 : m - a;
      OP_RED: res = a;
      default: res = (a == b) ? 64'd1 : 64'd0;
    endcase
    r.result = res[30:0];
    r.not_invertible = flag;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    mod_result_t e;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      modulus_reg <= 31'd1000000007;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == MODULUS_ADDR)
        modulus_reg <= pwdata[30:0];
      if (in_valid && !in_stall)
        expected_q.push_back(compute_mod_op(op_t'(in_opcode), in_operand_a,
                                            in_operand_b, modulus_reg));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transaction: result %0d", out_result);
          errs = errs + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.result !== out_result) begin
            $error("result: expected %0d, actual %0d", e.result, out_result);
            errs = errs + 1;
          end
          if (e.not_invertible !== out_not_invertible) begin
            $error("not_invertible: expected %0d, actual %0d", e.not_invertible,
                   out_not_invertible);
            errs = errs + 1;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

FILE: tb/modular_arithmetic_unit_tb.sv
module modular_arithmetic_unit_tb;
  import mau_pkg::*;

  localparam int         SETTLE_CYCLES = 12000;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_valid = 0;
  logic              in_stall;
  logic [2:0]        in_opcode = OP_ADD;
  logic [63:0]       in_operand_a = 0;
  logic [63:0]       in_operand_b = 0;
  logic              out_valid;
  logic              out_stall = 0;
  logic [30:0]       out_result;
  logic              out_not_invertible;
  logic              psel = 0;
  logic              penable = 0;
  logic              pwrite = 0;
  logic [2:0]        paddr = MODULUS_ADDR;
  logic [31:0]       pwdata = 0;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  bit                idling = 1;
  logic [63:0]       cur_mod = 64'd1000000007;

  always #4 clk = ~clk;

  modular_arithmetic_unit u_top (.*);

  modular_arithmetic_unit_checker u_checker (.*);

  always @(negedge clk)
    out_stall <= idling && ($urandom_range(0, 99) < 23);

  task automatic send(op_t op, logic [63:0] a, logic [63:0] b);
    logic stl;
    @(negedge clk);
    while (idling && $urandom_range(0, 99) < 23) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_opcode = op;
    in_operand_a = a;
    in_operand_b = b;
    forever begin
      stl = in_stall;
      @(posedge clk);
      if (!stl) break;
      @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_modulus(logic [31:0] v);
    drain();
    psel = 1; pwrite = 1; paddr = MODULUS_ADDR; pwdata = v;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    cur_mod = (v[30:0] < 2) ? 64'd1 : {33'd0, v[30:0]};
  endtask

  function automatic logic [63:0] pick_operand();
    logic [63:0] k;
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      3: begin
        k = $urandom_range(0, 5000);
        return k * cur_mod + $urandom_range(0, 2) - 1;
      end
      4: return -64'($urandom_range(0, 3) * cur_mod);
      default: return {32'd0, $urandom} % (cur_mod + 1);
    endcase
  endfunction

  task automatic random_items(int n);
    op_t         op;
    logic [63:0] a, b;
    repeat (n) begin
      op = op_t'($urandom_range(0, 7));
      a = pick_operand();
      b = pick_operand();
      if (op == OP_EQ && $urandom_range(0, 1)) b = a + cur_mod * $urandom_range(0, 2);
      if (op == OP_POW && $urandom_range(0, 2) != 0)
        b = 64'($signed($urandom_range(0, 200)) - 100);
      send(op, a, b);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1;
    send(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    send(OP_ADD, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send(OP_SUB, 0, 1);
    send(OP_SUB, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send(OP_MUL, -64'd1, -64'd1);
    send(OP_MUL, 64'd1000000006, 64'd1000000006);
    send(OP_DIV, 5, 0);
    send(OP_DIV, 7, 64'd1000000007);
    send(OP_DIV, 7, 3);
    send(OP_DIV, -64'd7, -64'd3);
    send(OP_POW, 0, 0);
    send(OP_POW, 5, 0);
    send(OP_POW, 2, 64'h8000_0000_0000_0000);
    send(OP_POW, 3, 64'h7FFF_FFFF_FFFF_FFFF);
    send(OP_POW, 0, -64'd1);
    send(OP_POW, 3, -64'd2);
    send(OP_NEG, 0, 0);
    send(OP_NEG, -64'd5, 0);
    send(OP_RED, 64'h8000_0000_0000_0000, 0);
    send(OP_RED, 64'd1000000007, 0);
    send(OP_EQ, 64'd1000000007, 0);
    send(OP_EQ, 1, 2);
    random_items(60);
    write_modulus(32'd2);
    random_items(60);
    idling = 0;
    write_modulus(32'hFFFF_FFFF);
    random_items(100);
    idling = 1;
    write_modulus(32'd0);
    random_items(40);
    write_modulus(32'd1);
    random_items(40);
    write_modulus(32'd12);
    random_items(90);
    write_modulus(32'h7FFF_FFFF);
    random_items(80);
    write_modulus($urandom_range(2, 32'h7FFF_FFFF));
    random_items(80);
    write_modulus(32'd97);
    random_items(60);
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
sv/mau_pkg.sv
sv/mau_divu.sv
sv/mau_front.sv
sv/mau_back.sv
sv/modular_arithmetic_unit.sv
tb/modular_arithmetic_unit_checker.sv
tb/modular_arithmetic_unit_tb.sv
